// ----- design/bcpg_pkg.sv -----
// Shared types and constants of the Bezier curve point generator.
// Used by the controller, the datapath and the top level; no dependencies.
package bcpg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int NUM_POINTS = 12;
	localparam int NUM_CTRL = 4;
	localparam int NUM_AXES = 3;
	localparam int IDX_W = 6;
	localparam int SEG_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;
	localparam int T_W = FRAC_BITS + 1;
	localparam int DIV_CNT_W = 5;
	localparam int W_W = T_W;
	localparam int PROD_W = W_W + 1 + COORD_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int TOTAL_W = PROD_W + 2;

	localparam logic [SEG_W-1:0] MAX_SEGMENTS = 6'd63;
	localparam logic [SEG_W-1:0] MIN_SEG_QUAD = 6'd3;
	localparam logic [SEG_W-1:0] MIN_SEG_CUBIC = 6'd4;
	localparam logic [SEG_W-1:0] RESET_SEGMENTS = 6'd16;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(T_W - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd1;

	typedef struct packed {
		logic start;
		logic div_step;
		logic div_first;
		logic issue;
		logic last;
		logic [IDX_W-1:0] index;
		logic [SEG_W-1:0] seg_n;
		logic cubic;
	} cmd_t;

	typedef struct packed {
		logic advance;
		logic final_done;
	} status_t;

endpackage

// ----- design/bcpg_ctrl.sv -----
// Controller of the Bezier curve point generator: configuration registers,
// request sequencing (divide, sample issue, drain). Depends on bcpg_pkg.
module bcpg_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [bcpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bcpg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  bcpg_pkg::status_t status,
	output bcpg_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DIVIDE = 4'b0010,
		ST_RUN    = 4'b0100,
		ST_DRAIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic mode_q;
	logic [bcpg_pkg::SEG_W-1:0] seg_q;
	logic [bcpg_pkg::SEG_W-1:0] n_q;
	logic [bcpg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [bcpg_pkg::IDX_W-1:0] index_q;
	logic [bcpg_pkg::SEG_W-1:0] seg_min;
	logic [bcpg_pkg::SEG_W-1:0] n_eff;
	logic accept;

	always_comb begin
		seg_min = mode_q ? bcpg_pkg::MIN_SEG_CUBIC : bcpg_pkg::MIN_SEG_QUAD;
		n_eff = seg_q;
		if (n_eff > bcpg_pkg::MAX_SEGMENTS) begin
			n_eff = bcpg_pkg::MAX_SEGMENTS;
		end
		if (n_eff < seg_min) begin
			n_eff = seg_min;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.start = 1'b0;
		cmd.div_step = 1'b0;
		cmd.div_first = (cnt_q == '0);
		cmd.issue = 1'b0;
		cmd.last = (index_q == n_q);
		cmd.index = index_q;
		cmd.seg_n = n_eff;
		cmd.cubic = mode_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (cnt_q == bcpg_pkg::DIV_LAST_STEP) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = status.advance;
				if (status.advance && (index_q == n_q)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.final_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= 1'b1;
			seg_q <= bcpg_pkg::RESET_SEGMENTS;
			n_q <= bcpg_pkg::RESET_SEGMENTS;
			cnt_q <= '0;
			index_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_index)
					bcpg_pkg::CFG_CURVE_MODE: mode_q <= cfg_data[0];
					bcpg_pkg::CFG_SEGMENT_COUNT: seg_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				n_q <= n_eff;
				cnt_q <= '0;
				index_q <= '0;
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.issue) begin
				index_q <= index_q + 1'b1;
			end
		end
	end

endmodule

// ----- design/bcpg_datapath.sv -----
// Datapath of the Bezier curve point generator: step divider, parameter
// accumulator, weight and product pipeline, output register. Uses bcpg_pkg.
module bcpg_datapath (
	input  logic clk,
	input  logic arst_n,
	input  bcpg_pkg::cmd_t cmd,
	output bcpg_pkg::status_t status,
	input  logic signed [bcpg_pkg::COORD_W-1:0] points [bcpg_pkg::NUM_POINTS],
	output logic out_valid,
	input  logic out_stall,
	output logic signed [bcpg_pkg::COORD_W-1:0] point_x,
	output logic signed [bcpg_pkg::COORD_W-1:0] point_y,
	output logic signed [bcpg_pkg::COORD_W-1:0] point_z,
	output logic [bcpg_pkg::IDX_W-1:0] sample_index,
	output logic last_sample
);

	localparam int T_W = bcpg_pkg::T_W;
	localparam int W_W = bcpg_pkg::W_W;
	localparam int FB = bcpg_pkg::FRAC_BITS;
	localparam int SEG_W = bcpg_pkg::SEG_W;
	localparam int IDX_W = bcpg_pkg::IDX_W;
	localparam int CW = bcpg_pkg::COORD_W;

	function automatic logic signed [CW-1:0] floor_sat(
		input logic signed [bcpg_pkg::TOTAL_W-1:0] total
	);
		logic signed [bcpg_pkg::TOTAL_W-1:0] q;
		logic signed [bcpg_pkg::TOTAL_W-1:0] lim_hi;
		logic signed [bcpg_pkg::TOTAL_W-1:0] lim_lo;
		q = total >>> FB;
		lim_hi = $signed({{(bcpg_pkg::TOTAL_W-CW+1){1'b0}}, {(CW-1){1'b1}}});
		lim_lo = $signed({{(bcpg_pkg::TOTAL_W-CW+1){1'b1}}, {(CW-1){1'b0}}});
		if (q > lim_hi) begin
			return lim_hi[CW-1:0];
		end else if (q < lim_lo) begin
			return lim_lo[CW-1:0];
		end
		return q[CW-1:0];
	endfunction

	logic signed [CW-1:0] pts_q [bcpg_pkg::NUM_POINTS];
	logic cubic_q;
	logic [SEG_W-1:0] n_q;
	logic [SEG_W:0] div_rem_q;
	logic [T_W-1:0] div_quo_q;
	logic [T_W-1:0] tacc_q;
	logic [SEG_W-1:0] racc_q;
	logic [SEG_W:0] div_trial;
	logic div_bit;
	logic [SEG_W:0] rsum;
	logic rcarry;
	logic advance;

	logic valid_s1, last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [T_W-1:0] t_s1, s_s1;
	logic valid_s2, last_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [T_W-1:0] t_s2, s_s2, a_s2, b_s2, m_s2;
	logic valid_s3, last_s3;
	logic [IDX_W-1:0] idx_s3;
	logic [W_W-1:0] w_s3 [bcpg_pkg::NUM_CTRL];
	logic valid_s4, last_s4;
	logic [IDX_W-1:0] idx_s4;
	logic signed [bcpg_pkg::PROD_W-1:0] prod_s4 [bcpg_pkg::NUM_AXES][bcpg_pkg::NUM_CTRL];
	logic valid_s5, last_s5;
	logic [IDX_W-1:0] idx_s5;
	logic signed [bcpg_pkg::PAIR_W-1:0] pair_s5 [bcpg_pkg::NUM_AXES][2];
	logic out_valid_q;
	logic signed [CW-1:0] res_q [bcpg_pkg::NUM_AXES];
	logic [IDX_W-1:0] idx_q;
	logic last_q;

	logic [2*T_W-1:0] ss_prod, tt_prod, as_prod, bt_prod;
	logic [2*T_W:0] ts2_prod, ta3_prod, sb3_prod;
	logic [T_W:0] t3, s3;
	logic signed [bcpg_pkg::TOTAL_W-1:0] total [bcpg_pkg::NUM_AXES];

	assign advance = !out_valid_q || !out_stall;
	assign status.advance = advance;
	assign status.final_done = out_valid_q && last_q && !out_stall;

	// Restoring division of 2^FRAC_BITS by n, one quotient bit per step, and the carry of the remainder accumulator.
	always_comb begin
		div_bit = cmd.div_first;
		div_trial = {div_rem_q[SEG_W-1:0], div_bit};
		rsum = {1'b0, racc_q} + div_rem_q;
		rcarry = (rsum >= {1'b0, n_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pts_q <= points;
			cubic_q <= cmd.cubic;
			n_q <= cmd.seg_n;
			div_rem_q <= '0;
			div_quo_q <= '0;
			tacc_q <= '0;
			racc_q <= '0;
		end
		if (cmd.div_step) begin
			if (div_trial >= {1'b0, n_q}) begin
				div_rem_q <= div_trial - {1'b0, n_q};
				div_quo_q <= {div_quo_q[T_W-2:0], 1'b1};
			end else begin
				div_rem_q <= div_trial;
				div_quo_q <= {div_quo_q[T_W-2:0], 1'b0};
			end
		end
		if (cmd.issue) begin
			if (rcarry) begin
				racc_q <= SEG_W'(rsum - {1'b0, n_q});
				tacc_q <= tacc_q + div_quo_q + 1'b1;
			end else begin
				racc_q <= rsum[SEG_W-1:0];
				tacc_q <= tacc_q + div_quo_q;
			end
		end
	end

	always_comb begin
		ss_prod = s_s1 * s_s1;
		tt_prod = t_s1 * t_s1;
		ts2_prod = {t_s1, 1'b0} * s_s1;
		t3 = {1'b0, t_s2} + {t_s2, 1'b0};
		s3 = {1'b0, s_s2} + {s_s2, 1'b0};
		as_prod = a_s2 * s_s2;
		bt_prod = b_s2 * t_s2;
		ta3_prod = t3 * a_s2;
		sb3_prod = s3 * b_s2;
		for (int c = 0; c < bcpg_pkg::NUM_AXES; c++) begin
			total[c] = bcpg_pkg::TOTAL_W'(pair_s5[c][0]) + bcpg_pkg::TOTAL_W'(pair_s5[c][1]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t_s1 <= tacc_q;
			s_s1 <= bcpg_pkg::T_ONE - tacc_q;
			idx_s1 <= cmd.index;
			last_s1 <= cmd.last;

			t_s2 <= t_s1;
			s_s2 <= s_s1;
			a_s2 <= ss_prod[FB+T_W-1:FB];
			b_s2 <= tt_prod[FB+T_W-1:FB];
			m_s2 <= ts2_prod[FB+T_W-1:FB];
			idx_s2 <= idx_s1;
			last_s2 <= last_s1;

			if (cubic_q) begin
				w_s3[0] <= as_prod[FB+W_W-1:FB];
				w_s3[1] <= ta3_prod[FB+W_W-1:FB];
				w_s3[2] <= sb3_prod[FB+W_W-1:FB];
				w_s3[3] <= bt_prod[FB+W_W-1:FB];
			end else begin
				w_s3[0] <= a_s2;
				w_s3[1] <= m_s2;
				w_s3[2] <= b_s2;
				w_s3[3] <= '0;
			end
			idx_s3 <= idx_s2;
			last_s3 <= last_s2;

			for (int c = 0; c < bcpg_pkg::NUM_AXES; c++) begin
				for (int p = 0; p < bcpg_pkg::NUM_CTRL; p++) begin
					prod_s4[c][p] <= $signed({1'b0, w_s3[p]}) * pts_q[p*bcpg_pkg::NUM_AXES + c];
				end
			end
			idx_s4 <= idx_s3;
			last_s4 <= last_s3;

			for (int c = 0; c < bcpg_pkg::NUM_AXES; c++) begin
				pair_s5[c][0] <= bcpg_pkg::PAIR_W'(prod_s4[c][0]) + bcpg_pkg::PAIR_W'(prod_s4[c][1]);
				pair_s5[c][1] <= bcpg_pkg::PAIR_W'(prod_s4[c][2]) + bcpg_pkg::PAIR_W'(prod_s4[c][3]);
			end
			idx_s5 <= idx_s4;
			last_s5 <= last_s4;

			for (int c = 0; c < bcpg_pkg::NUM_AXES; c++) begin
				res_q[c] <= floor_sat(total[c]);
			end
			idx_q <= idx_s5;
			last_q <= last_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			out_valid_q <= valid_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign point_x = res_q[0];
	assign point_y = res_q[1];
	assign point_z = res_q[2];
	assign sample_index = idx_q;
	assign last_sample = last_q;

endmodule

// ----- design/bezier_curve_point_generator_core.sv -----
// Top level of the Bezier curve point generator.
// Joins bcpg_ctrl and bcpg_datapath; types come from bcpg_pkg.
//
// Usage: a request carries four 3-D control points in signed Q16.16 on the
// input channel (in_valid, in_stall). The block answers with n+1 sampled
// points on the output channel (out_valid, out_stall), in order of index,
// with last_sample set on the final one. The config port (cfg_write,
// cfg_index, cfg_data) sets curve_mode (index 0) and segment_count
// (index 1); other indexes are ignored. Write it only while idle.
// After a transfer on the input, a restoring divider works out the parameter
// step, then the sample pipeline issues one point per cycle while out_stall
// does not hold a valid point. Each point passes stages s1 to s5 and the
// output register. The next request can be accepted in the cycle after the
// last point has been transferred. One request is handled at a time; in_stall
// is high from acceptance until the last point has been transferred. While
// out_stall holds a valid point, the whole sample pipeline freezes and the
// point stays on the outputs. Reset clears the controller to idle, empties
// the pipeline and restores curve_mode to cubic and segment_count to 16.
module bezier_curve_point_generator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [bcpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bcpg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p0_x,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p0_y,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p0_z,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p1_x,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p1_y,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p1_z,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p2_x,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p2_y,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p2_z,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p3_x,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p3_y,
	input  logic signed [bcpg_pkg::COORD_W-1:0] p3_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [bcpg_pkg::COORD_W-1:0] point_x,
	output logic signed [bcpg_pkg::COORD_W-1:0] point_y,
	output logic signed [bcpg_pkg::COORD_W-1:0] point_z,
	output logic [bcpg_pkg::IDX_W-1:0] sample_index,
	output logic last_sample
);

	bcpg_pkg::cmd_t cmd;
	bcpg_pkg::status_t status;
	logic signed [bcpg_pkg::COORD_W-1:0] points [bcpg_pkg::NUM_POINTS];

	assign points[0] = p0_x;
	assign points[1] = p0_y;
	assign points[2] = p0_z;
	assign points[3] = p1_x;
	assign points[4] = p1_y;
	assign points[5] = p1_z;
	assign points[6] = p2_x;
	assign points[7] = p2_y;
	assign points[8] = p2_z;
	assign points[9] = p3_x;
	assign points[10] = p3_y;
	assign points[11] = p3_z;

	bcpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bcpg_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.points       (points),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.sample_index (sample_index),
		.last_sample  (last_sample)
	);

endmodule
